### rtl/hjc_pkg.sv
// ----------------------------------------------------------------------------
// hjc_pkg - hangul jamo composer shared definitions
// Code point constants, lookup tables and types used by the composer.
// ----------------------------------------------------------------------------
`default_nettype none

package hjc_pkg;

  localparam int unsigned CpW        = 21;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned SlotW      = $clog2(MaxResults);

  localparam logic [CpW-1:0] CpLeadFirst     = 21'h01100;
  localparam logic [CpW-1:0] CpLeadLast      = 21'h01112;
  localparam logic [CpW-1:0] CpVowelFirst    = 21'h01161;
  localparam logic [CpW-1:0] CpVowelLast     = 21'h01175;
  localparam logic [CpW-1:0] CpTrailBase     = 21'h011A7;
  localparam logic [CpW-1:0] CpTrailFirst    = 21'h011A8;
  localparam logic [CpW-1:0] CpTrailLast     = 21'h011C2;
  localparam logic [CpW-1:0] CpCompatVowel   = 21'h0314F;
  localparam logic [CpW-1:0] CpSyllableBase  = 21'h0AC00;
  localparam logic [CpW-1:0] CpCaret         = 21'h0005E;
  localparam logic [CpW-1:0] CpNoCaretA      = 21'h03143;
  localparam logic [CpW-1:0] CpNoCaretB      = 21'h03149;
  localparam logic [CpW-1:0] CpNoCaretC      = 21'h03138;
  localparam logic [CpW-1:0] LeadStride      = 21'd588;
  localparam logic [CpW-1:0] VowelStride     = 21'd28;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEAD = 2'd1,
    PH_SYL  = 2'd2
  } phase_e;

  // results of one input item, slot 0 goes out first
  typedef struct packed {
    logic [MaxResults-1:0][CpW-1:0] pts;
    logic [CntW-1:0]                cnt;
  } res_t;

  typedef struct packed {
    logic pending;
  } core_status_t;

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [CntW-1:0] idx;
  } buf_status_t;

  function automatic logic [CpW-1:0] lead_compat(input logic [IdxW-1:0] idx);
    logic [CpW-1:0] v;
    case (idx)
      5'd0:    v = 21'h03131;
      5'd1:    v = 21'h03132;
      5'd2:    v = 21'h03134;
      5'd3:    v = 21'h03137;
      5'd4:    v = 21'h03138;
      5'd5:    v = 21'h03139;
      5'd6:    v = 21'h03141;
      5'd7:    v = 21'h03142;
      5'd8:    v = 21'h03143;
      5'd9:    v = 21'h03145;
      5'd10:   v = 21'h03146;
      5'd11:   v = 21'h03147;
      5'd12:   v = 21'h03148;
      5'd13:   v = 21'h03149;
      5'd14:   v = 21'h0314A;
      5'd15:   v = 21'h0314B;
      5'd16:   v = 21'h0314C;
      5'd17:   v = 21'h0314D;
      5'd18:   v = 21'h0314E;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [CpW-1:0] trail_compat(input logic [IdxW-1:0] idx);
    logic [CpW-1:0] v;
    case (idx)
      5'd1:    v = 21'h03131;
      5'd2:    v = 21'h03132;
      5'd3:    v = 21'h03133;
      5'd4:    v = 21'h03134;
      5'd5:    v = 21'h03135;
      5'd6:    v = 21'h03136;
      5'd7:    v = 21'h03137;
      5'd8:    v = 21'h03139;
      5'd9:    v = 21'h0313A;
      5'd10:   v = 21'h0313B;
      5'd11:   v = 21'h0313C;
      5'd12:   v = 21'h0313D;
      5'd13:   v = 21'h0313E;
      5'd14:   v = 21'h0313F;
      5'd15:   v = 21'h03140;
      5'd16:   v = 21'h03141;
      5'd17:   v = 21'h03142;
      5'd18:   v = 21'h03144;
      5'd19:   v = 21'h03145;
      5'd20:   v = 21'h03146;
      5'd21:   v = 21'h03147;
      5'd22:   v = 21'h03148;
      5'd23:   v = 21'h0314A;
      5'd24:   v = 21'h0314B;
      5'd25:   v = 21'h0314C;
      5'd26:   v = 21'h0314D;
      5'd27:   v = 21'h0314E;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [CpW-1:0] syllable(input logic [IdxW-1:0] lead,
                                              input logic [IdxW-1:0] vowel,
                                              input logic [IdxW-1:0] trail);
    return CpSyllableBase + CpW'(lead) * LeadStride + CpW'(vowel) * VowelStride
           + CpW'(trail);
  endfunction

  function automatic logic needs_caret(input logic [CpW-1:0] compat);
    return (compat != CpNoCaretA) && (compat != CpNoCaretB) && (compat != CpNoCaretC);
  endfunction

endpackage

`default_nettype wire

### rtl/hjc_core.sv
// ----------------------------------------------------------------------------
// hjc_core - composition state and result generation
// Holds the pending lead/vowel and turns one code point into up to four
// results combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module hjc_core
  import hjc_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [CpW-1:0] code_point_i,
  input  wire logic           end_of_text_i,
  output res_t                res_o,
  output core_status_t        status_o
);

  phase_e          phase_q, phase_d, mid_phase;
  logic [IdxW-1:0] lead_q, lead_d, vowel_q, vowel_d;

  logic            is_lead, is_vowel, is_trail;
  logic [IdxW-1:0] lead_idx, vowel_idx, trail_idx;

  assign is_lead   = (code_point_i >= CpLeadFirst)  && (code_point_i <= CpLeadLast);
  assign is_vowel  = (code_point_i >= CpVowelFirst) && (code_point_i <= CpVowelLast);
  assign is_trail  = (code_point_i >= CpTrailFirst) && (code_point_i <= CpTrailLast);
  assign lead_idx  = IdxW'(code_point_i - CpLeadFirst);
  assign vowel_idx = IdxW'(code_point_i - CpVowelFirst);
  assign trail_idx = IdxW'(code_point_i - CpTrailBase);

  // next state: mid_phase is the phase before the end-of-text flush
  always_comb begin
    mid_phase = PH_IDLE;
    lead_d    = lead_q;
    vowel_d   = vowel_q;
    unique case (phase_q)
      PH_LEAD: begin
        if (is_vowel) begin
          vowel_d   = vowel_idx;
          mid_phase = PH_SYL;
        end else if (is_lead) begin
          lead_d    = lead_idx;
          mid_phase = PH_LEAD;
        end
      end
      PH_SYL: begin
        if (!is_trail && is_lead) begin
          lead_d    = lead_idx;
          mid_phase = PH_LEAD;
        end
      end
      default: begin
        if (is_lead) begin
          lead_d    = lead_idx;
          mid_phase = PH_LEAD;
        end
      end
    endcase
    phase_d = end_of_text_i ? PH_IDLE : mid_phase;
  end

  // results
  always_comb begin
    logic [CntW-1:0] n;
    logic            do_fresh;
    logic [CpW-1:0]  held_compat;
    logic [CpW-1:0]  new_compat;
    n           = '0;
    do_fresh    = 1'b0;
    res_o.pts   = '0;
    held_compat = lead_compat(lead_q);
    new_compat  = lead_compat(lead_d);
    unique case (phase_q)
      PH_LEAD: begin
        if (!is_vowel) begin
          if (needs_caret(held_compat)) begin
            res_o.pts[n[SlotW-1:0]] = CpCaret;
            n = n + 1'b1;
          end
          res_o.pts[n[SlotW-1:0]] = held_compat;
          n = n + 1'b1;
          do_fresh = 1'b1;
        end
      end
      PH_SYL: begin
        res_o.pts[n[SlotW-1:0]] = syllable(lead_q, vowel_q, is_trail ? trail_idx : '0);
        n = n + 1'b1;
        do_fresh = !is_trail;
      end
      default: do_fresh = 1'b1;
    endcase
    if (do_fresh && !is_lead) begin
      if (is_vowel) begin
        res_o.pts[n[SlotW-1:0]] = CpW'(vowel_idx) + CpCompatVowel;
      end else if (is_trail) begin
        res_o.pts[n[SlotW-1:0]] = trail_compat(trail_idx);
      end else begin
        res_o.pts[n[SlotW-1:0]] = code_point_i;
      end
      n = n + 1'b1;
    end
    if (end_of_text_i) begin
      if (mid_phase == PH_LEAD) begin
        if (needs_caret(new_compat)) begin
          res_o.pts[n[SlotW-1:0]] = CpCaret;
          n = n + 1'b1;
        end
        res_o.pts[n[SlotW-1:0]] = new_compat;
        n = n + 1'b1;
      end else if (mid_phase == PH_SYL) begin
        res_o.pts[n[SlotW-1:0]] = syllable(lead_d, vowel_d, '0);
        n = n + 1'b1;
      end
    end
    res_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      lead_q  <= '0;
      vowel_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      lead_q  <= lead_d;
      vowel_q <= vowel_d;
    end
  end

  assign status_o.pending = (phase_q == PH_LEAD) || (phase_q == PH_SYL);

endmodule

`default_nettype wire

### rtl/hjc_obuf.sv
// ----------------------------------------------------------------------------
// hjc_obuf - result register and drain
// Holds the results of one item and hands them out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module hjc_obuf
  import hjc_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire res_t           res_i,
  output logic                space_o,
  output logic                valid_o,
  input  wire logic           ready_i,
  output logic [CpW-1:0]      point_o,
  output logic                last_o,
  output buf_status_t         status_o
);

  logic [MaxResults-1:0][CpW-1:0] pts_q;
  logic [CntW-1:0]                cnt_q, idx_q;
  logic                           pop;

  assign valid_o = idx_q < cnt_q;
  assign last_o  = idx_q == (cnt_q - 1'b1);
  assign point_o = pts_q[idx_q[SlotW-1:0]];
  assign pop     = valid_o && ready_i;
  // a new item may land as the last result of the current one leaves
  assign space_o = !valid_o || (pop && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= res_i.cnt;
      idx_q <= '0;
    end else if (pop) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pts_q <= res_i.pts;
    end
  end

  assign status_o.cnt = cnt_q;
  assign status_o.idx = idx_q;

endmodule

`default_nettype wire

### rtl/hangul_jamo_composer.sv
// ----------------------------------------------------------------------------
// hangul_jamo_composer - conjoining jamo to precomposed syllable composer
// Composes lead/vowel/trail jamo into syllables, maps lone jamo to their
// compatibility forms and passes other code points through.
//
//   channel  dir  tdata                    tlast        tuser
//   s_axis   in   [20:0] code_point        end_of_text  -
//   m_axis   out  [20:0] out_point         run_last     -
//
// an item is composed in the cycle it is accepted and its zero to four
// results sit in the result register, one leaving per transfer
// an item with at most one result keeps one item per cycle while m_axis is ready;
// an item with more results holds the input while the register drains
// the next item is taken in the same cycle the last result leaves
// reset clears the pending jamo and empties the result register
// ----------------------------------------------------------------------------
`default_nettype none

module hangul_jamo_composer
  import hjc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // [20:0] code_point, [23:21] zero
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [20:0] out_point, [23:21] zero
  output logic             m_axis_tlast_o
);

  logic           accept;
  logic           space;
  res_t           res;
  core_status_t   core_status;
  buf_status_t    buf_status;
  logic [CpW-1:0] out_point;

  assign s_axis_tready_o = space;
  assign accept          = s_axis_tvalid_i && space;

  hjc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .code_point_i  (s_axis_tdata_i[CpW-1:0]),
    .end_of_text_i (s_axis_tlast_i),
    .res_o         (res),
    .status_o      (core_status)
  );

  hjc_obuf u_obuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .res_i    (res),
    .space_o  (space),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .point_o  (out_point),
    .last_o   (m_axis_tlast_o),
    .status_o (buf_status)
  );

  assign m_axis_tdata_o = {3'b000, out_point};

  // while results are queued, a new item only lands as the last one leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && m_axis_tvalid_o) |-> (m_axis_tready_i && m_axis_tlast_o))
    else $error("input taken while results still queued");

  // results of one item come out back to back until tlast
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("result run cut short");

  // end of text leaves nothing pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast_i) |=> !core_status.pending)
    else $error("jamo pending after end of text");

  // the drain index never passes the result count, nor the count MaxResults
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_status.idx <= buf_status.cnt) && (buf_status.cnt <= CntW'(MaxResults)))
    else $error("result register count out of range");

endmodule

`default_nettype wire
